// File: sv/cos_pkg.sv
// Package for the circle overlap separation block: widths, stage map, pipeline record.
`default_nettype none
package cos_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int COORD_BITS = 21;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int ROOT_BITS  = COORD_BITS;
    localparam int REM_BITS   = 2 * ROOT_BITS + 1;
    localparam int Q_BITS     = COORD_BITS;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int CL_BITS    = COORD_BITS + 3;

    localparam int IN_BITS  = ((4 * COORD_BITS + 2 * RAD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ((1 + 4 * COORD_BITS + 7) / 8) * 8;

    // Stage map of the pipeline.
    localparam int ST_IN    = 0;
    localparam int ST_DIFF  = 1;
    localparam int ST_SQ    = 2;
    localparam int ST_CMP   = 3;
    localparam int ST_SQRT  = 4;
    localparam int ST_MUL   = ST_SQRT + ROOT_BITS;
    localparam int ST_NUM   = ST_MUL + 1;
    localparam int ST_DIV   = ST_NUM + 1;
    localparam int ST_PUSH  = ST_DIV + Q_BITS;
    localparam int ST_CLAMP = ST_PUSH + 1;
    localparam int NSTAGE   = ST_CLAMP + 1;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_TOP    = 2'd1;
    localparam logic [1:0] CFG_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_BOTTOM = 2'd3;

    localparam logic [RAD_BITS-1:0] LIMIT_FAR_RST = RAD_BITS'(1024 << FRAC_BITS);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
        logic [RAD_BITS-1:0]          r1;
        logic [RAD_BITS-1:0]          r2;
        logic                         xneg;
        logic                         yneg;
        logic [DIFF_BITS-1:0]         adx;
        logic [DIFF_BITS-1:0]         ady;
        logic [RAD_BITS:0]            rsum;
        logic [SQ_BITS-1:0]           sqx;
        logic [SQ_BITS-1:0]           sqy;
        logic [SQ_BITS-1:0]           rsq;
        logic                         hit;
        logic [REM_BITS-1:0]          rem;
        logic [ROOT_BITS-1:0]         root;
        logic [REM_BITS-1:0]          numx;
        logic [REM_BITS-1:0]          numy;
        logic [Q_BITS-1:0]            qx;
        logic [Q_BITS-1:0]            qy;
        logic signed [SUM_BITS-1:0]   tx1;
        logic signed [SUM_BITS-1:0]   ty1;
        logic signed [SUM_BITS-1:0]   tx2;
        logic signed [SUM_BITS-1:0]   ty2;
        logic [OUT_BITS-1:0]          result;
    } pipe_t;

endpackage
`default_nettype wire

// File: sv/circle_overlap_separation.sv
// Top level of the circle overlap separation block: a fully pipelined datapath.
// Throughput: one transaction per cycle while the output side does not stall;
// the root (21 stages, one bit each) and the push divider (21 stages, one
// quotient bit each) set the depth of the pipeline.
// A stall on the output side holds every stage in place; nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears all valid bits and sets the box limits.
`default_nettype none
module circle_overlap_separation
    import cos_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [RAD_BITS-1:0]   cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius, zero fill
    input  wire logic [IN_BITS-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // overlapped, new_first_x, new_first_y, new_second_x, new_second_y, zero fill
    output logic [OUT_BITS-1:0]        m_tdata
);

    logic [RAD_BITS-1:0] left_reg, top_reg, right_reg, bottom_reg;
    pipe_t               pipe_reg  [NSTAGE];
    pipe_t               pipe_next [NSTAGE];
    logic [NSTAGE-1:0]   valid_reg;
    logic                advance;

    // The whole pipeline moves as one shift register whenever the last stage is free.
    assign advance  = !valid_reg[NSTAGE-1] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = pipe_reg[NSTAGE-1].result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= LIMIT_FAR_RST;
            bottom_reg <= LIMIT_FAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT:   left_reg   <= cfg_wdata;
                CFG_TOP:    top_reg    <= cfg_wdata;
                CFG_RIGHT:  right_reg  <= cfg_wdata;
                CFG_BOTTOM: bottom_reg <= cfg_wdata;
                default:    left_reg   <= left_reg;
            endcase
        end
    end

    // Two clamp passes exactly as specified, then saturation to the coordinate range.
    function automatic logic [COORD_BITS-1:0] clamp_out(
        input logic signed [SUM_BITS-1:0] t_in,
        input logic [RAD_BITS-1:0]        r,
        input logic [RAD_BITS-1:0]        low_edge,
        input logic [RAD_BITS-1:0]        high_edge
    );
        logic signed [CL_BITS-1:0] t, lo, hi;
        logic signed [CL_BITS-1:0] cmax, cmin;
        t    = CL_BITS'(t_in);
        lo   = $signed(CL_BITS'(r)) + $signed(CL_BITS'(low_edge));
        hi   = $signed(CL_BITS'(high_edge)) - $signed(CL_BITS'(r));
        cmax = $signed(CL_BITS'({1'b0, {(COORD_BITS-1){1'b1}}}));
        cmin = -$signed(CL_BITS'({1'b1, {(COORD_BITS-1){1'b0}}}));
        if (t < lo)
            t = lo;
        else if (t > hi)
            t = hi;
        if (t > hi)
            t = hi;
        else if (t < lo)
            t = lo;
        if (t > cmax)
            t = cmax;
        if (t < cmin)
            t = cmin;
        return t[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        logic signed [DIFF_BITS-1:0] dx, dy;
        logic [REM_BITS-1:0]         trial, dsh;
        logic [SQ_BITS-1:0]          dsum;
        logic signed [Q_BITS:0]      px, py;
        logic [DIFF_BITS-1:0]        den;
        logic [RAD_BITS:0]           gap;
        logic                        ovl;
        logic [COORD_BITS-1:0]       o1x, o1y, o2x, o2y;
        pipe_t                       p;
        for (int k = 0; k < NSTAGE; k++)
        begin
            p = (k == 0) ? pipe_reg[0] : pipe_reg[k-1];
            if (k == ST_IN)
            begin
                p.x1 = s_tdata[COORD_BITS-1:0];
                p.y1 = s_tdata[2*COORD_BITS-1:COORD_BITS];
                p.r1 = s_tdata[2*COORD_BITS+RAD_BITS-1:2*COORD_BITS];
                p.x2 = s_tdata[3*COORD_BITS+RAD_BITS-1:2*COORD_BITS+RAD_BITS];
                p.y2 = s_tdata[4*COORD_BITS+RAD_BITS-1:3*COORD_BITS+RAD_BITS];
                p.r2 = s_tdata[4*COORD_BITS+2*RAD_BITS-1:4*COORD_BITS+RAD_BITS];
            end
            else if (k == ST_DIFF)
            begin
                dx     = DIFF_BITS'(p.x1) - DIFF_BITS'(p.x2);
                dy     = DIFF_BITS'(p.y1) - DIFF_BITS'(p.y2);
                p.xneg = dx[DIFF_BITS-1];
                p.yneg = dy[DIFF_BITS-1];
                p.adx  = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
                p.ady  = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
                p.rsum = (RAD_BITS+1)'(p.r1) + (RAD_BITS+1)'(p.r2);
            end
            else if (k == ST_SQ)
            begin
                p.sqx = SQ_BITS'(p.adx) * SQ_BITS'(p.adx);
                p.sqy = SQ_BITS'(p.ady) * SQ_BITS'(p.ady);
                p.rsq = SQ_BITS'(p.rsum) * SQ_BITS'(p.rsum);
            end
            else if (k == ST_CMP)
            begin
                // The magnitude checks keep the sum of squares from wrapping.
                dsum  = p.sqx + p.sqy;
                p.hit = (p.adx < DIFF_BITS'(p.rsum)) && (p.ady < DIFF_BITS'(p.rsum))
                        && (dsum < p.rsq);
                p.rem  = p.hit ? REM_BITS'(dsum) : '0;
                p.root = '0;
            end
            else if (k >= ST_SQRT && k < ST_MUL)
            begin
                // One root bit per stage, from the top bit down.
                trial = (REM_BITS'(p.root) << (ROOT_BITS - (k - ST_SQRT)))
                        | (REM_BITS'(1) << (2 * (ROOT_BITS - 1 - (k - ST_SQRT))));
                if (p.rem >= trial)
                begin
                    p.rem  = p.rem - trial;
                    p.root = p.root | (ROOT_BITS'(1) << (ROOT_BITS - 1 - (k - ST_SQRT)));
                end
            end
            else if (k == ST_MUL)
            begin
                gap    = p.rsum - (RAD_BITS+1)'(p.root);
                p.numx = REM_BITS'(p.adx) * REM_BITS'(gap);
                p.numy = REM_BITS'(p.ady) * REM_BITS'(gap);
            end
            else if (k == ST_NUM)
            begin
                // Adding the distance rounds the halved quotient to nearest.
                p.numx = p.numx + REM_BITS'(p.root);
                p.numy = p.numy + REM_BITS'(p.root);
                p.qx   = '0;
                p.qy   = '0;
            end
            else if (k >= ST_DIV && k < ST_PUSH)
            begin
                den = {p.root, 1'b0};
                dsh = REM_BITS'(den) << (Q_BITS - 1 - (k - ST_DIV));
                if (p.numx >= dsh)
                begin
                    p.numx = p.numx - dsh;
                    p.qx   = p.qx | (Q_BITS'(1) << (Q_BITS - 1 - (k - ST_DIV)));
                end
                if (p.numy >= dsh)
                begin
                    p.numy = p.numy - dsh;
                    p.qy   = p.qy | (Q_BITS'(1) << (Q_BITS - 1 - (k - ST_DIV)));
                end
            end
            else if (k == ST_PUSH)
            begin
                // Coincident centers give no push.
                px = '0;
                py = '0;
                if (p.root != '0)
                begin
                    px = p.xneg ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
                    py = p.yneg ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
                end
                p.tx1 = SUM_BITS'(p.x1) + SUM_BITS'(px);
                p.ty1 = SUM_BITS'(p.y1) + SUM_BITS'(py);
                p.tx2 = SUM_BITS'(p.x2) - SUM_BITS'(px);
                p.ty2 = SUM_BITS'(p.y2) - SUM_BITS'(py);
            end
            else
            begin
                ovl = p.hit;
                if (p.hit)
                begin
                    o1x = clamp_out(p.tx1, p.r1, left_reg, right_reg);
                    o1y = clamp_out(p.ty1, p.r1, top_reg, bottom_reg);
                    o2x = clamp_out(p.tx2, p.r2, left_reg, right_reg);
                    o2y = clamp_out(p.ty2, p.r2, top_reg, bottom_reg);
                end
                else
                begin
                    o1x = p.x1;
                    o1y = p.y1;
                    o2x = p.x2;
                    o2y = p.y2;
                end
                p.result = OUT_BITS'({o2y, o2x, o1y, o1x, ovl});
            end
            pipe_next[k] = p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[NSTAGE-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NSTAGE; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

endmodule
`default_nettype wire

// File: sv/cos_checker.sv
// Port-level checker for the circle overlap separation block and its bind.
`default_nettype none
module cos_checker
    import cos_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OUT_BITS-1:0] m_tdata
);

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input not ready while output side is ready");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped during stall");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed during stall");

endmodule

bind circle_overlap_separation cos_checker u_cos_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
